/* sv/mme_pkg.sv */
// Shared types, constants and helper functions for the matrix multiply engine.
// Depends on nothing; every other file of the block refers to it by scoped names.

package mme_pkg;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = 40;
    localparam int ROW_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic                     kind;
        logic signed [ELEM_W-1:0] element;
    } t_in_req;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [ROW_W-1:0]        out_col;
        logic signed [SUM_W-1:0] sum_value;
        logic                    last;
    } t_out_res;

    // one multiply-accumulate term as it travels down the datapath
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_term;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             last;
    } t_issue;

    typedef struct packed {
        logic busy;
    } t_mac_status;

    // 0 counts as 1, anything above MAX_DIM counts as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] mat_size(input logic [DIM_W-1:0] a,
                                                  input logic [DIM_W-1:0] b);
        logic [2*DIM_W-1:0] p;
        p = a * b;
        return CNT_W'(p);
    endfunction

endpackage

/* sv/mme_ram.sv */
// Element store: one write port, one read port, registered read data.
// Depends on mme_pkg for depth and element width.

module mme_ram (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [mme_pkg::ADDR_W-1:0]       i_waddr,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_wdata,
    input  logic [mme_pkg::ADDR_W-1:0]       i_raddr,
    output logic signed [mme_pkg::ELEM_W-1:0] o_rdata
);

    logic signed [mme_pkg::ELEM_W-1:0] r_mem [mme_pkg::DEPTH];
    logic signed [mme_pkg::ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mme_seq.sv */
// Controller: configuration registers, load counters and the read sequencer
// that walks (row, col, term) over both element stores. Depends on mme_pkg.

module mme_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mme_pkg::t_in_req               i_in_req,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_we_a,
    output logic                           o_we_b,
    output logic [mme_pkg::ADDR_W-1:0]     o_waddr_a,
    output logic [mme_pkg::ADDR_W-1:0]     o_waddr_b,
    output logic [mme_pkg::ADDR_W-1:0]     o_raddr_a,
    output logic [mme_pkg::ADDR_W-1:0]     o_raddr_b,
    output mme_pkg::t_issue                o_issue,
    input  mme_pkg::t_mac_status           i_mac_status
);

    mme_pkg::t_state r_state, n_state;

    logic [mme_pkg::CFG_W-1:0]  r_rows_a, r_inner_dim, r_cols_b;
    logic [mme_pkg::CNT_W-1:0]  r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [mme_pkg::IDX_W-1:0]  r_i, r_j, r_t, n_i, n_j, n_t;
    logic [mme_pkg::ADDR_W-1:0] r_a_base, r_b_addr, n_a_base, n_b_addr;

    logic [mme_pkg::DIM_W-1:0]  dim_m, dim_k, dim_n;
    logic [mme_pkg::CNT_W-1:0]  size_a, size_b, cnt_a_inc, cnt_b_inc;
    logic                       accept, store_a, store_b, complete;
    logic                       t_end, j_end, i_end;
    logic [mme_pkg::ADDR_W-1:0] a_addr;

    assign dim_m  = mme_pkg::eff_dim(r_rows_a);
    assign dim_k  = mme_pkg::eff_dim(r_inner_dim);
    assign dim_n  = mme_pkg::eff_dim(r_cols_b);
    assign size_a = mme_pkg::mat_size(dim_m, dim_k);
    assign size_b = mme_pkg::mat_size(dim_k, dim_n);

    assign accept  = i_in_valid && !o_in_stall;
    assign store_a = accept && !i_in_req.kind && (r_cnt_a < size_a);
    assign store_b = accept && i_in_req.kind && (r_cnt_b < size_b);

    assign cnt_a_inc = r_cnt_a + mme_pkg::CNT_W'(store_a);
    assign cnt_b_inc = r_cnt_b + mme_pkg::CNT_W'(store_b);
    // checked on every request, stored or dropped
    assign complete  = (cnt_a_inc >= size_a) && (cnt_b_inc >= size_b);

    assign t_end  = mme_pkg::DIM_W'(r_t) == dim_k - mme_pkg::DIM_W'(1);
    assign j_end  = mme_pkg::DIM_W'(r_j) == dim_n - mme_pkg::DIM_W'(1);
    assign i_end  = mme_pkg::DIM_W'(r_i) == dim_m - mme_pkg::DIM_W'(1);
    assign a_addr = r_a_base + mme_pkg::ADDR_W'(r_t);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mme_pkg::ST_LOAD: begin
                if (accept && complete) begin
                    n_state = mme_pkg::ST_RUN;
                end
            end
            mme_pkg::ST_RUN: begin
                if (t_end) begin
                    n_state = mme_pkg::ST_WAIT;
                end
            end
            mme_pkg::ST_WAIT: begin
                if (!i_mac_status.busy) begin
                    n_state = (i_end && j_end) ? mme_pkg::ST_LOAD : mme_pkg::ST_RUN;
                end
            end
            default: n_state = mme_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall        = (r_state != mme_pkg::ST_LOAD);
        o_cfg_ready       = 1'b1;
        o_we_a            = store_a;
        o_we_b            = store_b;
        o_waddr_a         = r_cnt_a[mme_pkg::ADDR_W-1:0];
        o_waddr_b         = r_cnt_b[mme_pkg::ADDR_W-1:0];
        o_raddr_a         = a_addr;
        o_raddr_b         = r_b_addr;
        o_issue.valid     = (r_state == mme_pkg::ST_RUN);
        o_issue.first     = (r_t == '0);
        o_issue.last_term = t_end;
        o_issue.row       = mme_pkg::ROW_W'(r_i);
        o_issue.col       = mme_pkg::ROW_W'(r_j);
        o_issue.last      = i_end && j_end;
    end

    // counters and address walk
    always_comb begin
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_i      = r_i;
        n_j      = r_j;
        n_t      = r_t;
        n_a_base = r_a_base;
        n_b_addr = r_b_addr;
        case (r_state)
            mme_pkg::ST_LOAD: begin
                if (accept) begin
                    n_cnt_a = cnt_a_inc;
                    n_cnt_b = cnt_b_inc;
                    if (complete) begin
                        n_cnt_a  = '0;
                        n_cnt_b  = '0;
                        n_i      = '0;
                        n_j      = '0;
                        n_t      = '0;
                        n_a_base = '0;
                        n_b_addr = '0;
                    end
                end
            end
            mme_pkg::ST_RUN: begin
                if (t_end) begin
                    n_t = '0;
                end else begin
                    n_t      = r_t + mme_pkg::IDX_W'(1);
                    n_b_addr = r_b_addr + mme_pkg::ADDR_W'(dim_n);
                end
            end
            mme_pkg::ST_WAIT: begin
                if (!i_mac_status.busy && !(i_end && j_end)) begin
                    if (j_end) begin
                        n_i      = r_i + mme_pkg::IDX_W'(1);
                        n_j      = '0;
                        n_a_base = r_a_base + mme_pkg::ADDR_W'(dim_k);
                        n_b_addr = '0;
                    end else begin
                        n_j      = r_j + mme_pkg::IDX_W'(1);
                        n_b_addr = mme_pkg::ADDR_W'(r_j) + mme_pkg::ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_cnt_a = r_cnt_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mme_pkg::ST_LOAD;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_rows_a    <= mme_pkg::CFG_W'(8);
            r_inner_dim <= mme_pkg::CFG_W'(8);
            r_cols_b    <= mme_pkg::CFG_W'(8);
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mme_pkg::REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                    mme_pkg::REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                    mme_pkg::REG_COLS_B:    r_cols_b    <= i_cfg_data;
                    default:                r_rows_a    <= r_rows_a;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_t      <= n_t;
        r_a_base <= n_a_base;
        r_b_addr <= n_b_addr;
    end

    a_read_a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mme_pkg::ST_RUN) |-> (mme_pkg::CNT_W'(a_addr) < size_a))
        else $error("store A read beyond loaded matrix");

    a_read_b_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mme_pkg::ST_RUN) |-> (mme_pkg::CNT_W'(r_b_addr) < size_b))
        else $error("store B read beyond loaded matrix");

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mme_pkg::ST_LOAD) |-> (r_cnt_a == '0 && r_cnt_b == '0))
        else $error("load counters not cleared during compute");

endmodule

/* sv/mme_mac.sv */
// Multiply-accumulate datapath: read data stage, product register, 40-bit
// accumulator, finished-sum hold and output register. Depends on mme_pkg.

module mme_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mme_pkg::t_issue                   i_issue,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_rdata_a,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_rdata_b,
    output mme_pkg::t_mac_status              o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mme_pkg::t_out_res                 o_out_res
);

    mme_pkg::t_issue                   r_s1, r_s2;
    logic signed [mme_pkg::PROD_W-1:0] r_prod;
    logic signed [mme_pkg::SUM_W-1:0]  r_acc;
    logic signed [mme_pkg::SUM_W-1:0]  prod_ext;
    logic                              r_done;
    logic [mme_pkg::ROW_W-1:0]         r_fin_row, r_fin_col;
    logic                              r_fin_last;
    logic                              r_out_valid;
    mme_pkg::t_out_res                 r_out;
    logic                              load_out;

    assign prod_ext = mme_pkg::SUM_W'(r_prod);
    assign load_out = r_done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_issue;
            r_s2 <= r_s1;
            if (r_s2.valid && r_s2.last_term) begin
                r_done <= 1'b1;
            end else if (load_out) begin
                r_done <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_rdata_a * i_rdata_b;
        if (r_s2.valid) begin
            r_acc <= r_s2.first ? prod_ext : r_acc + prod_ext;
        end
        if (r_s2.valid && r_s2.last_term) begin
            r_fin_row  <= r_s2.row;
            r_fin_col  <= r_s2.col;
            r_fin_last <= r_s2.last;
        end
        if (load_out) begin
            r_out.out_row   <= r_fin_row;
            r_out.out_col   <= r_fin_col;
            r_out.sum_value <= r_acc;
            r_out.last      <= r_fin_last;
        end
    end

    assign o_status.busy = r_s1.valid || r_s2.valid || r_done;
    assign o_out_valid   = r_out_valid;
    assign o_out_res     = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2.valid && r_s2.first) |-> !r_done)
        else $error("new sum started while finished sum still held");

    a_done_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2.valid && r_s2.last_term) |=> r_done)
        else $error("finished sum not captured");

endmodule

/* sv/matrix_multiply_engine_unit.sv */
// Matrix multiply engine top: C = A * B over two element stores.
// Loading takes one request per cycle. The request that completes both matrices
// is followed by M*N results, each built from K reads of the store pair that
// pass through the read, product and accumulate stages and is then held and
// registered for output. Input is stalled during the whole compute pass.
// Synchronous active-low reset clears counters and sets all dimensions to 8.

module matrix_multiply_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mme_pkg::t_in_req              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mme_pkg::t_out_res             o_out_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]     i_cfg_data
);

    logic                              we_a, we_b;
    logic [mme_pkg::ADDR_W-1:0]        waddr_a, waddr_b, raddr_a, raddr_b;
    logic signed [mme_pkg::ELEM_W-1:0] rdata_a, rdata_b;
    mme_pkg::t_issue                   issue;
    mme_pkg::t_mac_status              mac_status;

    mme_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_we_a       (we_a),
        .o_we_b       (we_b),
        .o_waddr_a    (waddr_a),
        .o_waddr_b    (waddr_b),
        .o_raddr_a    (raddr_a),
        .o_raddr_b    (raddr_b),
        .o_issue      (issue),
        .i_mac_status (mac_status)
    );

    mme_ram u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (i_in_req.element),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mme_ram u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (i_in_req.element),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    mme_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b),
        .o_status    (mac_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

/* tb/tb_matrix_multiply_engine_unit.sv */
// Testbench for matrix_multiply_engine_unit: a directed table, then random products.
// Depends on mme_pkg and the block RTL; results are checked against an in-bench
// matrix product predictor.

module tb_matrix_multiply_engine_unit;

    localparam logic KIND_A       = 1'b0;
    localparam logic KIND_B       = 1'b1;
    localparam int   RANDOM_ITEMS = 420;
    localparam int   SETTLE       = 16;   // covers the pipeline drain

    typedef struct packed {
        logic                              is_cfg;
        mme_pkg::t_cfg_reg                 reg_idx;
        logic [mme_pkg::CFG_W-1:0]         reg_val;
        logic                              kind;
        logic signed [mme_pkg::ELEM_W-1:0] element;
        logic                              known;
        logic signed [mme_pkg::SUM_W-1:0]  typed_sum;
    } t_dir_row;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    mme_pkg::t_in_req              in_req    = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    mme_pkg::t_out_res             out_res;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mme_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mme_pkg::CFG_W-1:0]     cfg_data  = '0;

    // predictor state
    logic signed [mme_pkg::ELEM_W-1:0] mat_a [mme_pkg::DEPTH];
    logic signed [mme_pkg::ELEM_W-1:0] mat_b [mme_pkg::DEPTH];
    int unsigned                       loaded_a  = 0;
    int unsigned                       loaded_b  = 0;
    logic [mme_pkg::CFG_W-1:0]         rows_reg  = 4'd8;
    logic [mme_pkg::CFG_W-1:0]         inner_reg = 4'd8;
    logic [mme_pkg::CFG_W-1:0]         cols_reg  = 4'd8;
    mme_pkg::t_out_res                 pending_sums [$];
    t_dir_row                          dir_tab [$];

    int          n_errors     = 0;
    int          n_stored     = 0;
    int          n_products   = 0;
    int          n_sums_seen  = 0;
    int          n_cfg_writes = 0;
    int          burst_left   = 0;
    int unsigned stall_cyc    = 0;

    always #5 i_clk = ~i_clk;

    matrix_multiply_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // receiver stall pattern: quiet, light, heavy and long-stretch windows
    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        case (stall_cyc[9:7])
            3'd0, 3'd4: out_stall <= 1'b0;
            3'd1:       out_stall <= ($urandom_range(0, 3) == 0);
            3'd2:       out_stall <= ($urandom_range(0, 1) == 1);
            3'd3:       out_stall <= (stall_cyc[4:0] < 5'd20);
            default:    out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic report_error(input string what);
        $display("ERROR t=%0t %s", $time, what);
        n_errors++;
    endtask

    function automatic int unsigned dim_of(input logic [mme_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > mme_pkg::MAX_DIM) return mme_pkg::MAX_DIM;
        return v;
    endfunction

    function automatic logic [mme_pkg::CFG_W-1:0] rand_dim_value();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) return mme_pkg::CFG_W'($urandom_range(0, 3));
        if (pick < 18) return mme_pkg::CFG_W'($urandom_range(4, 8));
        return mme_pkg::CFG_W'($urandom_range(9, 15));
    endfunction

    function automatic t_dir_row cfg_row(input mme_pkg::t_cfg_reg idx,
                                         input logic [mme_pkg::CFG_W-1:0] val);
        t_dir_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row elem_row(input logic kind,
                                          input logic signed [mme_pkg::ELEM_W-1:0] el,
                                          input logic known,
                                          input logic signed [mme_pkg::SUM_W-1:0] typed_sum);
        t_dir_row r;
        r           = '0;
        r.kind      = kind;
        r.element   = el;
        r.known     = known;
        r.typed_sum = typed_sum;
        return r;
    endfunction

    // Store one request and, once both matrices are complete, queue every sum of C.
    task automatic matmul_step(input mme_pkg::t_in_req req, output logic stored,
                               output int sums);
        int unsigned                      m, k, n, i, j, t;
        logic signed [mme_pkg::SUM_W-1:0] acc;
        mme_pkg::t_out_res                r;
        m      = dim_of(rows_reg);
        k      = dim_of(inner_reg);
        n      = dim_of(cols_reg);
        stored = 1'b0;
        sums   = 0;
        if (req.kind == KIND_A) begin
            if (loaded_a < m * k) begin
                mat_a[loaded_a] = req.element;
                loaded_a++;
                stored = 1'b1;
            end
        end else if (loaded_b < k * n) begin
            mat_b[loaded_b] = req.element;
            loaded_b++;
            stored = 1'b1;
        end
        // checked even when nothing was stored: a shrunk dimension completes here
        if (loaded_a >= m * k && loaded_b >= k * n) begin
            for (i = 0; i < m; i++) begin
                for (j = 0; j < n; j++) begin
                    acc = '0;
                    for (t = 0; t < k; t++) begin
                        acc = acc + mat_a[i * k + t] * mat_b[t * n + j];
                    end
                    r.out_row   = i[mme_pkg::ROW_W-1:0];
                    r.out_col   = j[mme_pkg::ROW_W-1:0];
                    r.sum_value = acc;
                    r.last      = (i == m - 1 && j == n - 1);
                    pending_sums.push_back(r);
                    sums++;
                end
            end
            loaded_a = 0;
            loaded_b = 0;
        end
    endtask

    task automatic send_element(input logic kind,
                                input logic signed [mme_pkg::ELEM_W-1:0] el,
                                input logic known,
                                input logic signed [mme_pkg::SUM_W-1:0] typed_sum,
                                output int sums);
        mme_pkg::t_in_req  req;
        logic              stored;
        mme_pkg::t_out_res r;
        if (burst_left == 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2))
                @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        req.kind    = kind;
        req.element = el;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        burst_left--;
        matmul_step(req, stored, sums);
        if (stored) n_stored++;
        if (sums != 0) n_products++;
        if (known) begin
            r           = '0;
            r.sum_value = typed_sum;
            r.last      = 1'b1;
            pending_sums[pending_sums.size() - 1] = r;
        end
    endtask

    task automatic pause_until_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input mme_pkg::t_cfg_reg idx,
                             input logic [mme_pkg::CFG_W-1:0] val);
        pause_until_idle();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            mme_pkg::REG_ROWS_A:    rows_reg  = val;
            mme_pkg::REG_INNER_DIM: inner_reg = val;
            default:                cols_reg  = val;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        mme_pkg::t_out_res want;
        if (i_rst_n && out_valid && !out_stall) begin
            n_sums_seen++;
            if (pending_sums.size() == 0) begin
                report_error($sformatf("unexpected result row %0d col %0d sum %0d",
                                       out_res.out_row, out_res.out_col, out_res.sum_value));
            end else begin
                want = pending_sums.pop_front();
                if (out_res.out_row !== want.out_row)
                    report_error($sformatf("out_row %0d, want %0d",
                                           out_res.out_row, want.out_row));
                if (out_res.out_col !== want.out_col)
                    report_error($sformatf("out_col %0d, want %0d",
                                           out_res.out_col, want.out_col));
                if (out_res.sum_value !== want.sum_value)
                    report_error($sformatf("sum_value %0d, want %0d at row %0d col %0d",
                                           out_res.sum_value, want.sum_value,
                                           want.out_row, want.out_col));
                if (out_res.last !== want.last)
                    report_error($sformatf("last %0b, want %0b at row %0d col %0d",
                                           out_res.last, want.last,
                                           want.out_row, want.out_col));
            end
        end
    end

    initial begin
        int                                sums;
        int                                sent;
        int                                cut_at;
        int                                phase_no;
        int                                base;
        int unsigned                       size_a;
        int unsigned                       size_b;
        logic                              kind;
        logic signed [mme_pkg::ELEM_W-1:0] el;
        t_dir_row                          row;

        // 1x1x1 with zero dimensions: extreme products
        dir_tab.push_back(cfg_row(mme_pkg::REG_ROWS_A, 4'd0));
        dir_tab.push_back(cfg_row(mme_pkg::REG_INNER_DIM, 4'd0));
        dir_tab.push_back(cfg_row(mme_pkg::REG_COLS_B, 4'd1));
        dir_tab.push_back(elem_row(KIND_A, 16'sh8000, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh8000, 1'b1, 40'sd1073741824));
        dir_tab.push_back(elem_row(KIND_B, 16'sh7fff, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_A, 16'sh7fff, 1'b1, 40'sd1073676289));
        dir_tab.push_back(elem_row(KIND_A, 16'sh7fff, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh8000, 1'b1, -40'sd1073709056));
        // excess A requests are dropped
        dir_tab.push_back(elem_row(KIND_A, 16'sd5, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_A, 16'sd7, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_A, -16'sd1, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sd3, 1'b1, 40'sd15));
        // 2x1x8, column count above range
        dir_tab.push_back(cfg_row(mme_pkg::REG_ROWS_A, 4'd2));
        dir_tab.push_back(cfg_row(mme_pkg::REG_INNER_DIM, 4'd1));
        dir_tab.push_back(cfg_row(mme_pkg::REG_COLS_B, 4'd15));
        dir_tab.push_back(elem_row(KIND_A, 16'sh0100, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_A, -16'sh0080, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh7fff, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh8000, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sd1, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, -16'sd1, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh1234, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh5555, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, -16'sh2aab, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, 16'sh0000, 1'b0, '0));
        // partial 1x2x1 load completed by shrinking the inner dimension
        dir_tab.push_back(cfg_row(mme_pkg::REG_ROWS_A, 4'd1));
        dir_tab.push_back(cfg_row(mme_pkg::REG_INNER_DIM, 4'd2));
        dir_tab.push_back(cfg_row(mme_pkg::REG_COLS_B, 4'd1));
        dir_tab.push_back(elem_row(KIND_A, 16'sd4, 1'b0, '0));
        dir_tab.push_back(elem_row(KIND_B, -16'sd6, 1'b0, '0));
        dir_tab.push_back(cfg_row(mme_pkg::REG_INNER_DIM, 4'd1));
        dir_tab.push_back(elem_row(KIND_A, 16'sd9, 1'b1, -40'sd24));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[idx]) begin
            row = dir_tab[idx];
            if (row.is_cfg) begin
                cfg_write(row.reg_idx, row.reg_val);
            end else begin
                send_element(row.kind, row.element, row.known, row.typed_sum, sums);
            end
        end

        base     = n_stored;
        phase_no = 0;
        cut_at   = 0;
        while (n_stored - base < RANDOM_ITEMS) begin
            if (phase_no == 6) begin
                // largest product the stores hold
                cfg_write(mme_pkg::REG_ROWS_A, 4'd15);
                cfg_write(mme_pkg::REG_INNER_DIM, 4'd8);
                cfg_write(mme_pkg::REG_COLS_B, 4'd15);
            end else if (phase_no % 5 == 0 || phase_no == 7 || cut_at != 0) begin
                if ($urandom_range(0, 3) != 0)
                    cfg_write(mme_pkg::REG_ROWS_A, rand_dim_value());
                if ($urandom_range(0, 3) != 0)
                    cfg_write(mme_pkg::REG_INNER_DIM, rand_dim_value());
                if ($urandom_range(0, 3) != 0)
                    cfg_write(mme_pkg::REG_COLS_B, rand_dim_value());
            end else if ($urandom_range(0, 3) == 0) begin
                pause_until_idle();
            end
            // now and then a load is broken off and resumed under new dimensions
            cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
            sent   = 0;
            sums   = 0;
            while (sums == 0 && (cut_at == 0 || sent < cut_at)) begin
                size_a = dim_of(rows_reg) * dim_of(inner_reg);
                size_b = dim_of(inner_reg) * dim_of(cols_reg);
                if (loaded_a >= size_a && loaded_b < size_b) begin
                    kind = ($urandom_range(0, 9) == 0) ? KIND_A : KIND_B;
                end else if (loaded_b >= size_b && loaded_a < size_a) begin
                    kind = ($urandom_range(0, 9) == 0) ? KIND_B : KIND_A;
                end else begin
                    kind = ($urandom_range(0, 1) == 1) ? KIND_B : KIND_A;
                end
                case ($urandom_range(0, 9))
                    0:       el = 16'sh8000;
                    1:       el = 16'sh7fff;
                    2:       el = mme_pkg::ELEM_W'(int'($urandom_range(0, 511)) - 256);
                    default: el = mme_pkg::ELEM_W'($urandom);
                endcase
                send_element(kind, el, 1'b0, '0, sums);
                sent++;
            end
            phase_no++;
        end

        pause_until_idle();
        $display("Run covered %0d stored elements (%0d random), %0d products, %0d sums checked,",
                 n_stored, n_stored - base, n_products, n_sums_seen);
        $display("and %0d register writes with zero, in-range and above-range dimensions.",
                 n_cfg_writes);
        if (n_errors == 0) begin
            $display("matrix_multiply_engine_unit: match");
        end else begin
            $display("matrix_multiply_engine_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("matrix_multiply_engine_unit: mismatch");
        $finish;
    end

endmodule
